[design/tlprs_pkg.sv]
// Shared constants, codes and types of the two-level priority / round-robin scheduler.
// No dependencies.
package tlprs_pkg;

   localparam int DEF_MAX_TASKS = 64;
   localparam int ID_W          = 6;
   localparam int PRIO_W        = 8;
   localparam int TIME_W        = 16;
   localparam int QUANT_W       = 8;
   localparam int KEY_W         = PRIO_W + ID_W;
   localparam int ID_SPACE      = 1 << ID_W;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef enum logic [1:0] {
      SRC_IDLE = 2'd0,
      SRC_HEAP = 2'd1,
      SRC_FIFO = 2'd2
   } run_src_type;

   typedef struct packed {
      logic [1:0]        run_source;
      logic [ID_W-1:0]   running_id;
      logic              response_valid;
      logic [TIME_W-1:0] response_time;
      logic              done_res;
      logic [TIME_W-1:0] finish_time;
      logic [TIME_W-1:0] wait_time;
   } result_type;

   typedef struct packed {
      logic            push;
      logic            pop;
      logic [ID_W-1:0] push_id;
   } fifo_cmd_type;

endpackage

[design/tlprs_req_if.sv]
// Request channel of the scheduler: valid/ready plus one scheduler request.
// Depends on tlprs_pkg.
interface tlprs_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [tlprs_pkg::ID_W-1:0]      task_id;
   logic [tlprs_pkg::PRIO_W-1:0]    task_priority;
   logic [tlprs_pkg::TIME_W-1:0]    burst_length;

   modport source (output valid, kind, task_id, task_priority, burst_length, input ready);
   modport sink   (input valid, kind, task_id, task_priority, burst_length, output ready);
endinterface

[design/tlprs_rsp_if.sv]
// Response channel of the scheduler: valid/ready plus one tick report.
// Depends on tlprs_pkg.
interface tlprs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    run_source;
   logic [tlprs_pkg::ID_W-1:0]    running_id;
   logic                          response_valid;
   logic [tlprs_pkg::TIME_W-1:0]  response_time;
   logic                          done_res;
   logic [tlprs_pkg::TIME_W-1:0]  finish_time;
   logic [tlprs_pkg::TIME_W-1:0]  wait_time;

   modport source (output valid, run_source, running_id, response_valid, response_time,
                   done_res, finish_time, wait_time, input ready);
   modport sink   (input valid, run_source, running_id, response_valid, response_time,
                   done_res, finish_time, wait_time, output ready);
endinterface

[design/tlprs_rr_fifo.sv]
// Round-robin rotation queue of task ids: circular memory with head/tail/count.
// Depends on tlprs_pkg. Head entry is a registered read, valid in the cycle after a change.
module tlprs_rr_fifo #(
   parameter int DEPTH = tlprs_pkg::DEF_MAX_TASKS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tlprs_pkg::fifo_cmd_type             cmd,
   output logic [tlprs_pkg::ID_W-1:0]          head_id,
   output logic [$clog2(DEPTH+1)-1:0]          count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [tlprs_pkg::ID_W-1:0] mem [DEPTH];
   logic [tlprs_pkg::ID_W-1:0] head_q_ff;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
      wrap_inc = (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      do_pop  = cmd.pop && (count_ff != '0);
      do_push = cmd.push && ((count_ff != CW'(DEPTH)) || do_pop);
      head_in  = do_pop  ? wrap_inc(head_ff) : head_ff;
      tail_in  = do_push ? wrap_inc(tail_ff) : tail_ff;
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[tail_ff] <= cmd.push_id;
      end
      head_q_ff <= mem[head_ff];
   end

   assign head_id = head_q_ff;
   assign count   = count_ff;
endmodule

[design/two_level_priority_rr_scheduler_core.sv]
// Two-level scheduler core: per-task records in one memory, rotation queue in another.
// Depends on tlprs_pkg, tlprs_req_if, tlprs_rsp_if and tlprs_rr_fifo.
//
// An arrival request is handled in ST_IDLE. A tick request goes to ST_OUT when idle,
// through ST_FRD and ST_FRUN when run from the rotation queue, and through ST_LAST and
// ST_HRUN when the priority top runs (after ST_ROT_RD and ST_ROT when the rotation head
// is checked for a partly used quantum); when the top leaves the priority set (finished
// or quantum used) and other tasks remain, the new top is found in ST_SCAN by a scan of
// the task record memory, one id per cycle. The record memory has a single read port.
// The tick report sits in an output register; the next request is taken while it waits.
module two_level_priority_rr_scheduler_core #(
   parameter int MAX_TASKS = tlprs_pkg::DEF_MAX_TASKS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tlprs_req_if.sink                            req,
   tlprs_rsp_if.source                          rsp,
   input  logic                                 csr_write_enable,
   input  logic [tlprs_pkg::QUANT_W-1:0]        csr_write_data
);
   localparam int NUM_IDS = (MAX_TASKS < tlprs_pkg::ID_SPACE) ? MAX_TASKS
                                                              : tlprs_pkg::ID_SPACE;
   localparam int IW = $clog2(NUM_IDS);
   localparam int CW = $clog2(NUM_IDS+1);
   localparam int TW = tlprs_pkg::TIME_W;
   localparam int KW = tlprs_pkg::KEY_W;

   typedef struct packed {
      logic [TW-1:0]                 arrival;
      logic [TW-1:0]                 burst;
      logic [TW-1:0]                 remaining;
      logic [tlprs_pkg::QUANT_W-1:0] slice;
      logic [tlprs_pkg::PRIO_W-1:0]  prio;
   } rec_type;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_ROT_RD = 9'b000000010,
      ST_ROT    = 9'b000000100,
      ST_LAST   = 9'b000001000,
      ST_HRUN   = 9'b000010000,
      ST_FRD    = 9'b000100000,
      ST_FRUN   = 9'b001000000,
      ST_SCAN   = 9'b010000000,
      ST_OUT    = 9'b100000000
   } state_type;

   state_type                     state_ff, state_in;
   logic [TW-1:0]                 now_ff, now_in;
   logic [tlprs_pkg::QUANT_W-1:0] quantum_ff, quantum_in;
   logic [NUM_IDS-1:0]            present_ff, present_in;
   logic [NUM_IDS-1:0]            inheap_ff, inheap_in;
   logic [NUM_IDS-1:0]            started_ff, started_in;
   logic [CW-1:0]                 heap_cnt_ff, heap_cnt_in;
   logic [KW-1:0]                 top_ff, top_in;
   logic                          last_valid_ff, last_valid_in;
   logic [IW-1:0]                 last_id_ff, last_id_in;
   logic [IW-1:0]                 cur_id_ff, cur_id_in;
   tlprs_pkg::result_type         res_ff, res_in;
   logic [CW-1:0]                 scan_ff, scan_in;
   logic                          scan_vld_ff, scan_vld_in;
   logic [IW-1:0]                 scan_id_ff, scan_id_in;
   logic [KW-1:0]                 best_ff, best_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tlprs_pkg::result_type         rsp_data_ff, rsp_data_in;

   rec_type                       rec_mem [NUM_IDS];
   rec_type                       rec_q_ff;
   logic [IW-1:0]                 rec_raddr;
   logic                          rec_we;
   logic [IW-1:0]                 rec_waddr;
   rec_type                       rec_wdata;

   tlprs_pkg::fifo_cmd_type       fifo_cmd;
   logic [tlprs_pkg::ID_W-1:0]    fifo_head;
   logic [CW-1:0]                 fifo_count;

   tlprs_rr_fifo #(.DEPTH(NUM_IDS)) u_rr_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (fifo_cmd),
      .head_id (fifo_head),
      .count   (fifo_count)
   );

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_waddr] <= rec_wdata;
      end
      rec_q_ff <= rec_mem[rec_raddr];
   end

   always_comb begin
      logic [IW-1:0]                 req_idx;
      logic                          req_in_range;
      logic [KW-1:0]                 new_key;
      logic [TW-1:0]                 burst_fix;
      logic [IW-1:0]                 x_id;
      logic [tlprs_pkg::QUANT_W-1:0] q_eff;
      logic [TW-1:0]                 rem_new;
      logic [TW-1:0]                 fin;
      logic [tlprs_pkg::QUANT_W-1:0] slice_new;
      logic [KW-1:0]                 scan_key;

      req_idx      = req.task_id[IW-1:0];
      req_in_range = ((tlprs_pkg::ID_W+1)'(req.task_id) < (tlprs_pkg::ID_W+1)'(NUM_IDS));
      new_key      = {req.task_priority, req.task_id};
      burst_fix    = (req.burst_length == '0) ? TW'(1) : req.burst_length;
      x_id         = top_ff[IW-1:0];
      q_eff        = (quantum_ff == '0) ? tlprs_pkg::QUANT_W'(1) : quantum_ff;
      rem_new      = rec_q_ff.remaining - 1'b1;
      fin          = now_ff + 1'b1;
      slice_new    = rec_q_ff.slice + 1'b1;
      scan_key     = {rec_q_ff.prio, tlprs_pkg::ID_W'(scan_id_ff)};

      state_in      = state_ff;
      now_in        = now_ff;
      quantum_in    = csr_write_enable ? csr_write_data : quantum_ff;
      present_in    = present_ff;
      inheap_in     = inheap_ff;
      started_in    = started_ff;
      heap_cnt_in   = heap_cnt_ff;
      top_in        = top_ff;
      last_valid_in = last_valid_ff;
      last_id_in    = last_id_ff;
      cur_id_in     = cur_id_ff;
      res_in        = res_ff;
      scan_in       = scan_ff;
      scan_vld_in   = scan_vld_ff;
      scan_id_in    = scan_id_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      rec_raddr     = '0;
      rec_we        = 1'b0;
      rec_waddr     = cur_id_ff;
      rec_wdata     = rec_q_ff;
      fifo_cmd      = '0;
      req.ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.kind == tlprs_pkg::KIND_ARRIVAL) begin
                  if (req_in_range && !present_ff[req_idx]) begin
                     rec_we              = 1'b1;
                     rec_waddr           = req_idx;
                     rec_wdata.arrival   = now_ff;
                     rec_wdata.burst     = burst_fix;
                     rec_wdata.remaining = burst_fix;
                     rec_wdata.slice     = '0;
                     rec_wdata.prio      = req.task_priority;
                     present_in[req_idx] = 1'b1;
                     inheap_in[req_idx]  = 1'b1;
                     started_in[req_idx] = 1'b0;
                     heap_cnt_in         = heap_cnt_ff + 1'b1;
                     if (heap_cnt_ff == '0 || new_key < top_ff) begin
                        top_in = new_key;
                     end
                  end
               end else begin
                  res_in = '0;
                  if (heap_cnt_ff != '0) begin
                     state_in = (fifo_count != '0 && last_valid_ff) ? ST_ROT_RD : ST_LAST;
                  end else if (fifo_count != '0) begin
                     state_in = ST_FRD;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_ROT_RD: begin
            cur_id_in = fifo_head[IW-1:0];
            rec_raddr = fifo_head[IW-1:0];
            state_in  = ST_ROT;
         end
         ST_ROT: begin
            if (rec_q_ff.slice != '0) begin
               rec_we           = 1'b1;
               rec_wdata.slice  = '0;
               fifo_cmd.pop     = 1'b1;
               fifo_cmd.push    = 1'b1;
               fifo_cmd.push_id = tlprs_pkg::ID_W'(cur_id_ff);
            end
            state_in = ST_LAST;
         end
         ST_LAST: begin
            if (last_valid_ff && last_id_ff != x_id && inheap_ff[last_id_ff] &&
                started_ff[last_id_ff]) begin
               inheap_in[last_id_ff] = 1'b0;
               heap_cnt_in           = heap_cnt_ff - 1'b1;
               fifo_cmd.push         = 1'b1;
               fifo_cmd.push_id      = tlprs_pkg::ID_W'(last_id_ff);
            end
            rec_raddr = x_id;
            state_in  = ST_HRUN;
         end
         ST_HRUN: begin
            res_in.run_source = tlprs_pkg::SRC_HEAP;
            res_in.running_id = tlprs_pkg::ID_W'(x_id);
            if (!started_ff[x_id]) begin
               started_in[x_id]      = 1'b1;
               res_in.response_valid = 1'b1;
               res_in.response_time  = now_ff - rec_q_ff.arrival;
            end
            rec_we              = 1'b1;
            rec_waddr           = x_id;
            rec_wdata.remaining = rem_new;
            last_valid_in       = 1'b1;
            last_id_in          = x_id;
            state_in            = ST_OUT;
            if (rem_new == '0 || (rec_q_ff.burst - rem_new) == TW'(q_eff)) begin
               inheap_in[x_id] = 1'b0;
               heap_cnt_in     = heap_cnt_ff - 1'b1;
               if (rem_new == '0) begin
                  present_in[x_id]   = 1'b0;
                  res_in.done_res    = 1'b1;
                  res_in.finish_time = fin;
                  res_in.wait_time   = fin - rec_q_ff.arrival - rec_q_ff.burst;
               end else begin
                  fifo_cmd.push    = 1'b1;
                  fifo_cmd.push_id = tlprs_pkg::ID_W'(x_id);
               end
               if (heap_cnt_ff != CW'(1)) begin
                  scan_in     = '0;
                  scan_vld_in = 1'b0;
                  best_in     = '1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_FRD: begin
            cur_id_in = fifo_head[IW-1:0];
            rec_raddr = fifo_head[IW-1:0];
            state_in  = ST_FRUN;
         end
         ST_FRUN: begin
            res_in.run_source   = tlprs_pkg::SRC_FIFO;
            res_in.running_id   = tlprs_pkg::ID_W'(cur_id_ff);
            last_valid_in       = 1'b0;
            rec_we              = 1'b1;
            rec_wdata.remaining = rem_new;
            rec_wdata.slice     = slice_new;
            if (rem_new == '0) begin
               fifo_cmd.pop          = 1'b1;
               present_in[cur_id_ff] = 1'b0;
               res_in.done_res       = 1'b1;
               res_in.finish_time    = fin;
               res_in.wait_time      = fin - rec_q_ff.arrival - rec_q_ff.burst;
            end else if (slice_new == q_eff) begin
               rec_wdata.slice  = '0;
               fifo_cmd.pop     = 1'b1;
               fifo_cmd.push    = 1'b1;
               fifo_cmd.push_id = tlprs_pkg::ID_W'(cur_id_ff);
            end
            state_in = ST_OUT;
         end
         ST_SCAN: begin
            rec_raddr = scan_ff[IW-1:0];
            if (scan_ff < CW'(NUM_IDS)) begin
               scan_vld_in = 1'b1;
               scan_id_in  = scan_ff[IW-1:0];
               scan_in     = scan_ff + 1'b1;
            end else begin
               scan_vld_in = 1'b0;
            end
            if (scan_vld_ff && inheap_ff[scan_id_ff] && scan_key < best_ff) begin
               best_in = scan_key;
            end
            if (scan_ff == CW'(NUM_IDS) && !scan_vld_ff) begin
               top_in   = best_ff;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               now_in       = now_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         quantum_ff    <= tlprs_pkg::QUANTUM_RESET;
         present_ff    <= '0;
         inheap_ff     <= '0;
         started_ff    <= '0;
         heap_cnt_ff   <= '0;
         last_valid_ff <= 1'b0;
         scan_ff       <= '0;
         scan_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         quantum_ff    <= quantum_in;
         present_ff    <= present_in;
         inheap_ff     <= inheap_in;
         started_ff    <= started_in;
         heap_cnt_ff   <= heap_cnt_in;
         last_valid_ff <= last_valid_in;
         scan_ff       <= scan_in;
         scan_vld_ff   <= scan_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      last_id_ff  <= last_id_in;
      cur_id_ff   <= cur_id_in;
      res_ff      <= res_in;
      scan_id_ff  <= scan_id_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.run_source     = rsp_data_ff.run_source;
   assign rsp.running_id     = rsp_data_ff.running_id;
   assign rsp.response_valid = rsp_data_ff.response_valid;
   assign rsp.response_time  = rsp_data_ff.response_time;
   assign rsp.done_res       = rsp_data_ff.done_res;
   assign rsp.finish_time    = rsp_data_ff.finish_time;
   assign rsp.wait_time      = rsp_data_ff.wait_time;
endmodule

[sim/two_level_priority_rr_scheduler_core_test.sv]
// Self-checking test of the two-level priority / round-robin scheduler core.
// Depends on tlprs_pkg, tlprs_req_if, tlprs_rsp_if and the core itself.
// Requests are predicted in-line; reports are matched in order against the queue.
module two_level_priority_rr_scheduler_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit                    kind;
      bit [5:0]              id;
      bit [7:0]              prio;
      bit [15:0]             burst;
      bit                    typed;
      tlprs_pkg::result_type res;
   } sched_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [tlprs_pkg::QUANT_W-1:0] csr_write_data = '0;

   tlprs_req_if req_ch();
   tlprs_rsp_if rsp_ch();

   two_level_priority_rr_scheduler_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler shadow state
   bit [15:0] sim_now;
   bit [15:0] arrival_tm [64];
   bit [15:0] burst_tm [64];
   bit [15:0] remain_tm [64];
   bit [7:0]  slice_cnt [64];
   bit        started [64];
   bit        present [64];
   bit        in_heap [64];
   bit [13:0] prio_heap [64];
   int        heap_n;
   bit [5:0]  rr_ring [64];
   int        rr_head, rr_tail, rr_n;
   bit        last_ok;
   int        last_id;
   bit [7:0]  quantum;

   tlprs_pkg::result_type tick_reports [$];
   int errors = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   function automatic void shadow_reset();
      sim_now = 0;
      for (int i = 0; i < 64; i++) begin
         slice_cnt[i] = 0;
         started[i] = 0;
         present[i] = 0;
         in_heap[i] = 0;
      end
      heap_n = 0;
      rr_head = 0;
      rr_tail = 0;
      rr_n = 0;
      last_ok = 0;
      last_id = 0;
      quantum = tlprs_pkg::QUANTUM_RESET;
   endfunction

   function automatic void heap_up(int i);
      int p;
      bit [13:0] t;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (prio_heap[p] <= prio_heap[i]) break;
         t = prio_heap[p];
         prio_heap[p] = prio_heap[i];
         prio_heap[i] = t;
         i = p;
      end
   endfunction

   function automatic void heap_down(int i);
      int l, r, m;
      bit [13:0] t;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         m = i;
         if (l < heap_n && prio_heap[l] < prio_heap[m]) m = l;
         if (r < heap_n && prio_heap[r] < prio_heap[m]) m = r;
         if (m == i) break;
         t = prio_heap[m];
         prio_heap[m] = prio_heap[i];
         prio_heap[i] = t;
         i = m;
      end
   endfunction

   function automatic void heap_drop(int id);
      for (int i = 0; i < heap_n; i++) begin
         if (prio_heap[i][5:0] == id) begin
            heap_n--;
            if (i != heap_n) begin
               prio_heap[i] = prio_heap[heap_n];
               heap_up(i);
               heap_down(i);
            end
            in_heap[id] = 0;
            return;
         end
      end
   endfunction

   function automatic void rr_push(int id);
      if (rr_n >= 64) return;
      rr_ring[rr_tail] = 6'(id);
      rr_tail = (rr_tail + 1) % 64;
      rr_n++;
   endfunction

   function automatic void rr_pop();
      rr_head = (rr_head + 1) % 64;
      rr_n--;
   endfunction

   function automatic void finish_task(int id, ref tlprs_pkg::result_type r);
      bit [15:0] fin;
      fin = sim_now + 16'd1;
      r.done_res = 1'b1;
      r.finish_time = fin;
      r.wait_time = fin - arrival_tm[id] - burst_tm[id];
      present[id] = 0;
   endfunction

   // returns 1 when the request changed state or produced a report
   function automatic bit schedule_step(sched_row_type row, output bit has_rpt,
                                        output tlprs_pkg::result_type r);
      int q, x, f;
      bit [15:0] b;
      q = (quantum == 0) ? 1 : quantum;
      r = '0;
      has_rpt = 0;
      if (row.kind == tlprs_pkg::KIND_ARRIVAL) begin
         if (present[row.id] || heap_n >= 64) return 0;
         b = (row.burst == 0) ? 16'd1 : row.burst;
         arrival_tm[row.id] = sim_now;
         burst_tm[row.id] = b;
         remain_tm[row.id] = b;
         slice_cnt[row.id] = 0;
         started[row.id] = 0;
         present[row.id] = 1;
         in_heap[row.id] = 1;
         prio_heap[heap_n] = {row.prio, row.id};
         heap_n++;
         heap_up(heap_n - 1);
         return 1;
      end
      has_rpt = 1;
      if (heap_n > 0) begin
         x = prio_heap[0][5:0];
         if (rr_n > 0 && last_ok) begin
            f = rr_ring[rr_head];
            if (slice_cnt[f] != 0) begin
               rr_pop();
               slice_cnt[f] = 0;
               rr_push(f);
            end
         end
         if (last_ok && last_id != x && in_heap[last_id] && started[last_id]) begin
            heap_drop(last_id);
            rr_push(last_id);
         end
         r.run_source = tlprs_pkg::SRC_HEAP;
         r.running_id = 6'(x);
         if (!started[x]) begin
            started[x] = 1;
            r.response_valid = 1'b1;
            r.response_time = sim_now - arrival_tm[x];
         end
         remain_tm[x] = remain_tm[x] - 16'd1;
         if (remain_tm[x] == 0) begin
            heap_drop(x);
            finish_task(x, r);
         end else if (16'(burst_tm[x] - remain_tm[x]) == q) begin
            heap_drop(x);
            rr_push(x);
         end
         last_ok = 1;
         last_id = x;
      end else if (rr_n > 0) begin
         f = rr_ring[rr_head];
         last_ok = 0;
         r.run_source = tlprs_pkg::SRC_FIFO;
         r.running_id = 6'(f);
         slice_cnt[f] = slice_cnt[f] + 8'd1;
         remain_tm[f] = remain_tm[f] - 16'd1;
         if (remain_tm[f] == 0) begin
            rr_pop();
            finish_task(f, r);
         end else if (slice_cnt[f] == q) begin
            slice_cnt[f] = 0;
            rr_pop();
            rr_push(f);
         end
      end
      sim_now = sim_now + 16'd1;
      return 1;
   endfunction

   task automatic issue_request(sched_row_type row, output bit took);
      bit has_rpt;
      tlprs_pkg::result_type r;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= row.kind;
      req_ch.task_id <= row.id;
      req_ch.task_priority <= row.prio;
      req_ch.burst_length <= row.burst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      took = schedule_step(row, has_rpt, r);
      if (has_rpt) tick_reports.insert(tick_reports.size(), row.typed ? row.res : r);
   endtask

   task automatic drain_reports();
      req_ch.valid <= 1'b0;
      while (tick_reports.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // report side: random backpressure and in-order checking
   always @(posedge clock) begin
      tlprs_pkg::result_type e;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (tick_reports.size() == 0) begin
            $error("unexpected report id %0d", rsp_ch.running_id);
            errors++;
         end else begin
            e = tick_reports.pop_front();
            if (rsp_ch.run_source !== e.run_source) begin
               $error("run_source exp %0d got %0d", e.run_source, rsp_ch.run_source);
               errors++;
            end
            if (rsp_ch.running_id !== e.running_id) begin
               $error("running_id exp %0d got %0d", e.running_id, rsp_ch.running_id);
               errors++;
            end
            if (rsp_ch.response_valid !== e.response_valid) begin
               $error("response_valid exp %0d got %0d", e.response_valid,
                      rsp_ch.response_valid);
               errors++;
            end
            if (rsp_ch.response_time !== e.response_time) begin
               $error("response_time exp %0d got %0d", e.response_time,
                      rsp_ch.response_time);
               errors++;
            end
            if (rsp_ch.done_res !== e.done_res) begin
               $error("done_res exp %0d got %0d", e.done_res, rsp_ch.done_res);
               errors++;
            end
            if (rsp_ch.finish_time !== e.finish_time) begin
               $error("finish_time exp %0d got %0d", e.finish_time, rsp_ch.finish_time);
               errors++;
            end
            if (rsp_ch.wait_time !== e.wait_time) begin
               $error("wait_time exp %0d got %0d", e.wait_time, rsp_ch.wait_time);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 3000) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   sched_row_type directed [] = '{
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b1, '0},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd63, 8'd255, 16'd1,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b1,
        '{tlprs_pkg::SRC_HEAP, 6'd63, 1'b1, 16'd0, 1'b1, 16'd2, 16'd0}},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd0,  8'd7,   16'd9,     1'b0, '0},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd5,  8'd10,  16'd6,     1'b0, '0},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd2,  8'd10,  16'd3,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd1,  8'd0,   16'd3,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_ARRIVAL, 6'd63, 8'd128, 16'd65535, 1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0},
      '{tlprs_pkg::KIND_TICK,    6'd0,  8'd0,   16'd0,     1'b0, '0}
   };

   bit [7:0] quanta [] = '{8'd255, 8'd1, 8'd0, 8'd3, 8'd2};

   initial begin
      sched_row_type row;
      bit took;
      int n;
      req_ch.valid = 1'b0;
      req_ch.kind = tlprs_pkg::KIND_TICK;
      req_ch.task_id = '0;
      req_ch.task_priority = '0;
      req_ch.burst_length = '0;
      rsp_ch.ready = 1'b0;
      shadow_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) issue_request(directed[i], took);
      foreach (quanta[p]) begin
         drain_reports();
         csr_write_enable <= 1'b1;
         csr_write_data <= quanta[p];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         quantum = quanta[p];
         quiet = (p == quanta.size() - 1);
         n = 0;
         while (n < 80) begin
            row = '{default: '0};
            row.kind = ($urandom_range(0, 9) < 4) ? tlprs_pkg::KIND_ARRIVAL
                                                  : tlprs_pkg::KIND_TICK;
            if (row.kind == tlprs_pkg::KIND_ARRIVAL) begin
               row.id = $urandom_range(0, 1) ? 6'($urandom_range(0, 15))
                                             : 6'($urandom_range(0, 63));
               row.prio = 8'($urandom_range(0, 255));
               case ($urandom_range(0, 19))
                  0: row.burst = 16'($urandom_range(0, 65535));
                  1: row.burst = 16'd0;
                  default: row.burst = 16'($urandom_range(1, 10));
               endcase
            end else begin
               row.id = 6'($urandom_range(0, 63));
               row.prio = 8'($urandom_range(0, 255));
               row.burst = 16'($urandom_range(0, 65535));
            end
            issue_request(row, took);
            if (took) n++;
         end
      end
      drain_reports();
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
